// ===== rtl/glyph_atlas_fifo_cache_macros.svh =====
// Assertion macros for the glyph atlas cache, included by glyph_atlas_fifo_cache.sv.
`ifndef GLYPH_ATLAS_FIFO_CACHE_MACROS_SVH
`define GLYPH_ATLAS_FIFO_CACHE_MACROS_SVH

`ifndef SYNTHESIS

`define GAFC_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("glyph atlas cache: invariant violated");

`define GAFC_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glyph atlas cache: implication violated");

`define GAFC_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glyph atlas cache: next-cycle check violated");

`else

`define GAFC_ASSERT(label, cond)

`define GAFC_IMPLIES(label, ante, cons)

`define GAFC_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/gafc_pkg.sv =====
// Package with widths, register codes and shared types of the glyph atlas cache.
`default_nettype none

package gafc_pkg;

	localparam int CODE_W     = 16;
	localparam int ADV_W      = 8;
	localparam int SLOT_W     = 12;
	localparam int SLOTS      = 4096;
	localparam int CNT_W      = 13;
	localparam int DIM_W      = 11;
	localparam int ORG_W      = 10;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 64;
	localparam int RES_W      = 1 + 1 + SLOT_W + ORG_W + ORG_W + ADV_W + 1 + CODE_W;
	localparam int DIV_STEPS  = 3;
	localparam int DIV_CYCLES = SLOT_W / DIV_STEPS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

	localparam logic [DIM_W-1:0] CELL_SIZE_RST  = DIM_W'(16);
	localparam logic [DIM_W-1:0] COLUMNS_RST    = DIM_W'(64);
	localparam logic [CNT_W-1:0] SLOT_COUNT_RST = CNT_W'(SLOTS);
	localparam logic [ADV_W-1:0] BORDER_RST     = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELL_SIZE  = 2'd0,
		REG_COLUMNS    = 2'd1,
		REG_SLOT_COUNT = 2'd2,
		REG_BORDER     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [ADV_W-1:0]  adv;
		logic [CODE_W-1:0] code;
	} slot_entry_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [SLOT_W-1:0] quot;
		logic [DIM_W-1:0]  rem;
	} div_res_t;

endpackage

`default_nettype wire

// ===== rtl/gafc_divider.sv =====
// Iterative restoring divider that splits a slot index into atlas row and column.
`default_nettype none

module gafc_divider (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [gafc_pkg::SLOT_W-1:0] dividend,
	input  wire logic [gafc_pkg::DIM_W-1:0]  divisor,
	output gafc_pkg::div_res_t             res
);
	import gafc_pkg::*;

	logic [SLOT_W-1:0]    dvd_q;
	logic [DIM_W-1:0]     rem_q;
	logic [DIM_W-1:0]     dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [SLOT_W-1:0]    dvd_n;
	logic [DIM_W-1:0]     rem_n;

	always_comb begin
		logic [DIM_W:0] trial;
		logic           qbit;
		dvd_n = dvd_q;
		rem_n = rem_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {rem_n, dvd_n[SLOT_W-1]};
			if (trial >= {1'b0, dsr_q}) begin
				trial = trial - {1'b0, dsr_q};
				qbit  = 1'b1;
			end else begin
				qbit  = 1'b0;
			end
			rem_n = trial[DIM_W-1:0];
			dvd_n = {dvd_n[SLOT_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_CYCLES);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= (divisor == '0) ? DIM_W'(1) : divisor;
		end else if (busy_q && (cnt_q != '0)) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
	end

	assign res.busy = busy_q;
	assign res.done = busy_q && (cnt_q == '0);
	assign res.quot = dvd_q;
	assign res.rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/glyph_atlas_fifo_cache.sv =====
// Glyph atlas cache: code lookup, round-robin slot fill and cell origin output.
//
// Requests arrive on the s_ channel, one character code with its rasterizer
// advance and load flag each; every request gives exactly one result on m_.
// The user must write settings through cfg_wr_en, cfg_addr and cfg_wdata only
// while idle; the block does not enforce this. A code map memory of 65536 entries
// points each code at a slot, and a slot memory of 4096 entries holds the code
// and advance that a slot stores; a hit is a map entry whose slot is filled and
// still holds the same code. A request runs through a map read, a slot read and
// a compare with write-back, then a divider that yields the cell row and column.
// A request that returns a glyph passes through the divider before its result
// is shown; an invalid code or a failed load skips the divider. The next
// request is taken only once the result has gone to the output register.
// After reset the block clears the code map, one entry a cycle, and takes no
// request until the map is cleared; settings return to their defaults at once.
// The result sits in an output register, so a stalled receiver holds only the
// final hand-over and the block waits there until the register is free.
`default_nettype none

module glyph_atlas_fifo_cache (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [gafc_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [gafc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// Fields from bit 0: char_code, glyph_advance, raster_ok.
	input  wire logic [gafc_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// Fields from bit 0: valid_res, hit, slot, cell_x, cell_y, advance,
	// evicted_valid, evicted_char.
	output logic [gafc_pkg::M_TDATA_W-1:0]       m_tdata
);
	import gafc_pkg::*;

	`include "glyph_atlas_fifo_cache_macros.svh"

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_LOOK  = 6'b000100,
		ST_CHECK = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q, state_n;

	logic [DIM_W-1:0]  cell_size_q;
	logic [DIM_W-1:0]  columns_q;
	logic [CNT_W-1:0]  slot_count_q;
	logic [ADV_W-1:0]  border_q;

	logic [CNT_W-1:0]  cursor_q;
	logic [CNT_W-1:0]  hwm_q;
	logic [CODE_W-1:0] clr_q;

	logic [CODE_W-1:0] code_q;
	logic [ADV_W-1:0]  adv_q;
	logic              ok_q;
	logic [SLOT_W-1:0] fill_slot_q;
	logic [CODE_W-1:0] evict_code_q;

	logic              res_valid_q;
	logic              res_hit_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [ADV_W-1:0]  res_adv_q;
	logic              res_ev_valid_q;
	logic [CODE_W-1:0] res_ev_char_q;
	logic [ORG_W-1:0]  x_q;
	logic [ORG_W-1:0]  y_q;

	logic              out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic [SLOT_W-1:0] map_mem [2**CODE_W];
	slot_entry_t       slot_mem [SLOTS];
	logic [SLOT_W-1:0] map_rd_q;
	slot_entry_t       slot_rd_q;

	logic [CODE_W-1:0] in_code;
	logic [ADV_W-1:0]  in_adv;
	logic              in_ok;
	logic              accept;
	logic [CNT_W-1:0]  limit;
	logic [SLOT_W-1:0] s_eff;
	logic              map_used;
	logic              hit;
	logic              fill;
	logic              ev_valid;
	logic [ADV_W-1:0]  new_adv;
	logic [CNT_W-1:0]  fill_next;
	logic              map_we;
	logic [CODE_W-1:0] map_wa;
	logic [SLOT_W-1:0] map_wd;
	logic              slot_re;
	logic [SLOT_W-1:0] slot_ra;
	logic              out_load;
	logic              div_start;
	logic [DIM_W-1:0]  cols_eff;
	logic [2*DIM_W-1:0]         x_prod;
	logic [SLOT_W+DIM_W-1:0]    y_prod;
	div_res_t          div_res;

	assign in_code = s_tdata[CODE_W-1:0];
	assign in_adv  = s_tdata[CODE_W +: ADV_W];
	assign in_ok   = s_tdata[CODE_W+ADV_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (slot_count_q == '0) begin
			limit = CNT_W'(1);
		end else if (slot_count_q > CNT_W'(SLOTS)) begin
			limit = CNT_W'(SLOTS);
		end else begin
			limit = slot_count_q;
		end
	end

	assign s_eff    = (cursor_q >= limit) ? '0 : cursor_q[SLOT_W-1:0];
	assign cols_eff = (columns_q == '0) ? DIM_W'(1) : columns_q;

	always_comb begin
		map_used = ({1'b0, map_rd_q} < hwm_q);
		hit      = (code_q != '0) && map_used && (slot_rd_q.code == code_q);
		fill     = (code_q != '0) && !hit && ok_q;
		ev_valid = fill && ({1'b0, fill_slot_q} < hwm_q);
	end

	assign new_adv   = adv_q + border_q;
	assign fill_next = {1'b0, fill_slot_q} + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q  <= CELL_SIZE_RST;
			columns_q    <= COLUMNS_RST;
			slot_count_q <= SLOT_COUNT_RST;
			border_q     <= BORDER_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_CELL_SIZE:  cell_size_q  <= cfg_wdata[DIM_W-1:0];
				REG_COLUMNS:    columns_q    <= cfg_wdata[DIM_W-1:0];
				REG_SLOT_COUNT: slot_count_q <= cfg_wdata[CNT_W-1:0];
				REG_BORDER:     border_q     <= cfg_wdata[ADV_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == '1) state_n = ST_IDLE;
			ST_IDLE:  if (accept) state_n = ST_LOOK;
			ST_LOOK:  state_n = ST_CHECK;
			ST_CHECK: state_n = (hit || fill) ? ST_DIV : ST_OUT;
			ST_DIV:   if (div_res.done) state_n = ST_OUT;
			ST_OUT:   if (!out_valid_q || m_tready) state_n = ST_IDLE;
			default:  state_n = ST_CLEAR;
		endcase
	end

	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || m_tready);
	assign div_start = (state_q == ST_CHECK) && (hit || fill);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cursor_q    <= '0;
			hwm_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CODE_W'(1);
			end
			if ((state_q == ST_CHECK) && fill) begin
				cursor_q <= fill_next;
				if (fill_next > hwm_q) begin
					hwm_q <= fill_next;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_q      <= in_code;
			adv_q       <= in_adv;
			ok_q        <= in_ok;
			fill_slot_q <= s_eff;
		end
		if (state_q == ST_LOOK) begin
			evict_code_q <= slot_rd_q.code;
		end
		if (state_q == ST_CHECK) begin
			res_valid_q    <= hit || fill;
			res_hit_q      <= hit;
			res_slot_q     <= hit ? map_rd_q : (fill ? fill_slot_q : '0);
			res_adv_q      <= hit ? slot_rd_q.adv : (fill ? new_adv : '0);
			res_ev_valid_q <= ev_valid;
			res_ev_char_q  <= ev_valid ? evict_code_q : '0;
			x_q            <= '0;
			y_q            <= '0;
		end else if ((state_q == ST_DIV) && div_res.done) begin
			x_q <= x_prod[ORG_W-1:0];
			y_q <= y_prod[ORG_W-1:0];
		end
		if (out_load) begin
			out_data_q <= {{(M_TDATA_W-RES_W){1'b0}}, res_ev_char_q, res_ev_valid_q,
				res_adv_q, y_q, x_q, res_slot_q, res_hit_q, res_valid_q};
		end
	end

	always_comb begin
		map_we = 1'b0;
		map_wa = code_q;
		map_wd = fill_slot_q;
		if (state_q == ST_CLEAR) begin
			map_we = 1'b1;
			map_wa = clr_q;
			map_wd = '0;
		end else if ((state_q == ST_CHECK) && fill) begin
			map_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (accept) begin
			map_rd_q <= map_mem[in_code];
		end
	end

	assign slot_re = accept || (state_q == ST_LOOK);
	assign slot_ra = (state_q == ST_LOOK) ? map_rd_q : s_eff;

	always_ff @(posedge clk) begin
		if ((state_q == ST_CHECK) && fill) begin
			slot_mem[fill_slot_q] <= '{adv: new_adv, code: code_q};
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_ra];
		end
	end

	gafc_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (hit ? map_rd_q : fill_slot_q),
		.divisor  (cols_eff),
		.res      (div_res)
	);

	assign x_prod = {{DIM_W{1'b0}}, div_res.rem} * {{DIM_W{1'b0}}, cell_size_q};
	assign y_prod = {{DIM_W{1'b0}}, div_res.quot} * {{SLOT_W{1'b0}}, cell_size_q};

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`GAFC_ASSERT(a_hwm_range, hwm_q <= CNT_W'(SLOTS))
	`GAFC_IMPLIES(a_fill_in_limit, (state_q == ST_CHECK) && fill, CNT_W'(fill_slot_q) < limit)
	`GAFC_NEXT(a_fill_marks_used, (state_q == ST_CHECK) && fill, hwm_q > CNT_W'(fill_slot_q))
	`GAFC_IMPLIES(a_done_in_div, div_res.done, state_q == ST_DIV)
	`GAFC_IMPLIES(a_accept_div_idle, accept, !div_res.busy)

endmodule

`default_nettype wire

// ===== bench/glyph_atlas_fifo_cache_tb.sv =====
// Self-checking bench for the glyph atlas cache, predicting every lookup result.
`default_nettype none

module glyph_atlas_fifo_cache_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gafc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic              raster_ok;
		logic [ADV_W-1:0]  glyph_advance;
		logic [CODE_W-1:0] char_code;
	} glyph_request_t;

	typedef struct packed {
		logic [CODE_W-1:0] evicted_char;
		logic              evicted_valid;
		logic [ADV_W-1:0]  advance;
		logic [ORG_W-1:0]  cell_y;
		logic [ORG_W-1:0]  cell_x;
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic              valid_res;
	} glyph_entry_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// Fields from bit 0: char_code, glyph_advance, raster_ok.
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// Fields from bit 0: valid_res, hit, slot, cell_x, cell_y, advance,
	// evicted_valid, evicted_char.
	logic [M_TDATA_W-1:0]  m_tdata;

	logic [DIM_W-1:0] cur_cell_size = CELL_SIZE_RST;
	logic [DIM_W-1:0] cur_columns = COLUMNS_RST;
	logic [CNT_W-1:0] cur_slot_count = SLOT_COUNT_RST;
	logic [ADV_W-1:0] cur_border = BORDER_RST;

	logic [CODE_W-1:0] slot_code [SLOTS];
	logic [ADV_W-1:0]  slot_adv [SLOTS];
	bit                slot_used [SLOTS];
	int unsigned       slot_of_code [int unsigned];
	int unsigned       fill_cursor = 0;

	glyph_request_t glyph_requests [$];
	glyph_entry_t   awaited_entries [$];

	int unsigned mismatch_count = 0;
	int unsigned sent_count = 0;
	int unsigned send_wait = 0;
	int unsigned received = 0;
	int unsigned recv_wait = 0;
	int unsigned hold_left = 0;
	glyph_entry_t got_entry;
	glyph_entry_t want_entry;

	glyph_atlas_fifo_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic glyph_entry_t lookup_glyph(glyph_request_t req);
		glyph_entry_t res;
		int unsigned limit;
		int unsigned s;
		int unsigned cols;
		res = '0;
		if (req.char_code == '0) begin
			return res;
		end
		if (slot_of_code.exists(req.char_code)) begin
			s = slot_of_code[req.char_code];
			res.hit = 1'b1;
		end else begin
			if (!req.raster_ok) begin
				return res;
			end
			limit = cur_slot_count;
			if (limit < 1) begin
				limit = 1;
			end
			if (limit > SLOTS) begin
				limit = SLOTS;
			end
			s = (fill_cursor >= limit) ? 0 : fill_cursor;
			if (slot_used[s]) begin
				res.evicted_valid = 1'b1;
				res.evicted_char = slot_code[s];
				slot_of_code.delete(slot_code[s]);
			end
			slot_code[s] = req.char_code;
			slot_used[s] = 1'b1;
			slot_adv[s] = ADV_W'(req.glyph_advance + cur_border);
			slot_of_code[req.char_code] = s;
			fill_cursor = s + 1;
		end
		cols = (cur_columns == '0) ? 1 : cur_columns;
		res.valid_res = 1'b1;
		res.slot = SLOT_W'(s);
		res.advance = slot_adv[s];
		res.cell_x = ORG_W'((s % cols) * cur_cell_size);
		res.cell_y = ORG_W'((s / cols) * cur_cell_size);
		return res;
	endfunction

	function automatic int unsigned draw_wait(int unsigned count);
		if ((count / 64) % 3 == 2) begin
			return 0;
		end
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic glyph_request_t random_request(int unsigned pool);
		glyph_request_t req;
		int unsigned pick;
		pick = $urandom_range(0, 15);
		req.glyph_advance = ADV_W'($urandom_range(0, 255));
		req.raster_ok = ($urandom_range(0, 7) != 0);
		if (pick == 0) begin
			req.char_code = '0;
		end else if (pick <= 2) begin
			req.char_code = CODE_W'($urandom_range(1, 65535));
		end else begin
			req.char_code = CODE_W'($urandom_range(1, pool) * 40503);
		end
		return req;
	endfunction

	function automatic void queue_request(logic [CODE_W-1:0] code, logic [ADV_W-1:0] adv,
			logic ok);
		glyph_request_t req;
		req.char_code = code;
		req.glyph_advance = adv;
		req.raster_ok = ok;
		glyph_requests = {glyph_requests, req};
	endfunction

	function automatic void check_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic write_setting(cfg_reg_t which, int unsigned value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= which;
		cfg_wdata <= CFG_DATA_W'(value);
		case (which)
			REG_CELL_SIZE: begin
				cur_cell_size = DIM_W'(value);
			end
			REG_COLUMNS: begin
				cur_columns = DIM_W'(value);
			end
			REG_SLOT_COUNT: begin
				cur_slot_count = CNT_W'(value);
			end
			default: begin
				cur_border = ADV_W'(value);
			end
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (glyph_requests.size() != 0 || s_tvalid || awaited_entries.size() != 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic run_phase(int unsigned cell_px, int unsigned col_count,
			int unsigned slot_limit, int unsigned border_px, int unsigned pool,
			int unsigned count);
		wait_drained();
		write_setting(REG_CELL_SIZE, cell_px);
		write_setting(REG_COLUMNS, col_count);
		write_setting(REG_SLOT_COUNT, slot_limit);
		write_setting(REG_BORDER, border_px);
		@(negedge clk);
		repeat (count) begin
			glyph_requests = {glyph_requests, random_request(pool)};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				awaited_entries = {awaited_entries,
					lookup_glyph(glyph_request_t'(s_tdata[$bits(glyph_request_t)-1:0]))};
				sent_count++;
				send_wait = draw_wait(sent_count);
			end
			if (!s_tvalid || s_tready) begin
				if (send_wait != 0) begin
					send_wait--;
					s_tvalid <= 1'b0;
				end else if (glyph_requests.size() != 0) begin
					s_tdata <= S_TDATA_W'(glyph_requests.pop_front());
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// The receiver twice holds off for a long stretch so that the cache backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_entry = glyph_entry_t'(m_tdata[$bits(glyph_entry_t)-1:0]);
				if (awaited_entries.size() == 0) begin
					$error("result with no request outstanding: %h", m_tdata);
					mismatch_count++;
				end else begin
					want_entry = awaited_entries.pop_front();
					check_field("valid_res", want_entry.valid_res, got_entry.valid_res);
					check_field("hit", want_entry.hit, got_entry.hit);
					check_field("slot", want_entry.slot, got_entry.slot);
					check_field("cell_x", want_entry.cell_x, got_entry.cell_x);
					check_field("cell_y", want_entry.cell_y, got_entry.cell_y);
					check_field("advance", want_entry.advance, got_entry.advance);
					check_field("evicted_valid", want_entry.evicted_valid,
						got_entry.evicted_valid);
					check_field("evicted_char", want_entry.evicted_char,
						got_entry.evicted_char);
					check_field("padding", 0, m_tdata[M_TDATA_W-1:$bits(glyph_entry_t)]);
				end
				received++;
				recv_wait = draw_wait(received);
				if (received == 400 || received == 1100) begin
					hold_left = 600;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_wait != 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		for (int unsigned n = 0; n < CYCLE_LIMIT; n++) begin
			@(posedge clk);
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		queue_request(16'h0000, 8'hff, 1'b1);
		queue_request(16'h0000, 8'h00, 1'b0);
		queue_request(16'hffff, 8'hff, 1'b0);
		queue_request(16'hffff, 8'hff, 1'b1);
		queue_request(16'hffff, 8'h00, 1'b0);
		queue_request(16'h0001, 8'h00, 1'b1);
		queue_request(16'h8000, 8'h80, 1'b1);
		queue_request(16'h5555, 8'h7f, 1'b1);
		queue_request(16'haaaa, 8'h01, 1'b1);
		queue_request(16'h0001, 8'hff, 1'b1);
		wait_drained();
		write_setting(REG_BORDER, 255);
		write_setting(REG_CELL_SIZE, 1000);
		write_setting(REG_COLUMNS, 3);
		write_setting(REG_SLOT_COUNT, 2);
		@(negedge clk);
		queue_request(16'h1234, 8'h02, 1'b1);
		queue_request(16'hffff, 8'h10, 1'b0);
		queue_request(16'h8000, 8'h00, 1'b0);
		queue_request(16'h4321, 8'hff, 1'b1);
		queue_request(16'h0fff, 8'h00, 1'b1);
		queue_request(16'h5555, 8'h00, 1'b1);
		queue_request(16'haaaa, 8'h00, 1'b0);
		run_phase(8, 5, 12, 3, 18, 300);
		run_phase(1024, 1, 1, 255, 3, 120);
		run_phase(1, 1024, 4096, 0, 400, 250);
		run_phase(2047, 0, 0, 128, 4, 100);
		run_phase(24, 7, 8191, 200, 600, 200);
		run_phase(37, 3, 40, 17, 60, 400);
		run_phase(0, 2047, 5, 1, 8, 150);
		run_phase(16, 64, 4096, 0, 30, 130);
		wait_drained();
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
